/* hdl/cuckoo_filter_engine_core_macros.svh */
// assertion macros for the cuckoo filter engine checker
`ifndef CUCKOO_FILTER_ENGINE_CORE_MACROS_SVH
`define CUCKOO_FILTER_ENGINE_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define CFE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cuckoo filter engine check failed");

// next-cycle implication, disabled in reset
`define CFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cuckoo filter engine check failed");

`endif

/* hdl/cfe_pkg.sv */
// shared types, constants and fingerprint hash table for the cuckoo filter engine
`default_nettype none

package cfe_pkg;

  localparam int MAX_SLOTS = 4;
  localparam int HASH_BITS = 20;

  localparam logic [9:0]  MAX_KICKS_RESET = 10'd500;
  localparam logic [15:0] SEED_RESET      = 16'd44257;
  localparam logic [15:0] LFSR_MASK       = 16'hB400;

  localparam logic [63:0] P64_1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] P64_2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] P64_3 = 64'h165667B19E3779F9;
  localparam logic [63:0] P64_5 = 64'h27D4EB2F165667C5;

  localparam logic CFG_MAX_KICKS = 1'b0;
  localparam logic CFG_SEED      = 1'b1;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_CONTAINS = 2'd1,
    CMD_DELETE   = 2'd2,
    CMD_COUNT    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [MAX_SLOTS-1:0] match;
    logic [MAX_SLOTS-1:0] empty;
    logic [2:0]           count;
  } scan_t;

  typedef logic [HASH_BITS-1:0] hash_lo_t;
  typedef hash_lo_t [255:0] hash_tbl_t;

  // single-byte xxh64, seed 0
  function automatic logic [63:0] byte_hash(input logic [7:0] v);
    logic [63:0] h;
    h = P64_5 + 64'd1;
    h = h ^ ({56'd0, v} * P64_5);
    h = {h[52:0], h[63:53]};
    h = h * P64_1;
    h = h ^ (h >> 33);
    h = h * P64_2;
    h = h ^ (h >> 29);
    h = h * P64_3;
    h = h ^ (h >> 32);
    return h;
  endfunction

  function automatic hash_tbl_t build_hash_tbl();
    hash_tbl_t   t;
    logic [63:0] hv;
    for (int i = 0; i < 256; i++) begin
      hv   = byte_hash(8'(i));
      t[i] = hv[HASH_BITS-1:0];
    end
    return t;
  endfunction

  localparam hash_tbl_t HASH_TBL = build_hash_tbl();

endpackage

`default_nettype wire

/* hdl/cfe_bucket_ram.sv */
// bucket memory: one row per bucket, one write and one registered read port
`default_nettype none

module cfe_bucket_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/cfe_bucket_scan.sv */
// compares every slot of a bucket row against a fingerprint and flags empty (zero) slots
`default_nettype none

module cfe_bucket_scan import cfe_pkg::*; #(
  parameter int SLOTS = 4
) (
  input  logic [SLOTS*8-1:0] row,
  input  logic [7:0]         fp,
  output scan_t              res
);

  always_comb begin
    res = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (row[s*8 +: 8] == fp) begin
        res.match[s] = 1'b1;
        res.count    = res.count + 3'd1;
      end
      if (row[s*8 +: 8] == 8'd0) begin
        res.empty[s] = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/cuckoo_filter_engine_core.sv */
// cuckoo filter engine top level: command sequencer around the bucket memory
//
// input channel in_valid/in_ready carries cmd and key_hash; output channel
// out_valid/out_ready carries ok and match_count, one result per transaction.
// one command is worked on at a time. a lookup, delete, count or an add that
// finds a free slot goes through S_B1, S_B2 and S_DONE before its result is
// shown and the engine is back in S_IDLE for the next command; the two bucket
// reads of the single-read-port memory set this. an add that has to evict
// adds eviction rounds, each one swap (S_KSWAP) and one probe of the
// alternate bucket (S_KPLACE), at most max_kicks rounds.
// after reset the bucket memory is cleared one bucket per cycle, through all
// NUM_BUCKETS buckets; in_ready stays low meanwhile, config writes still land.
// the result sits in an output register; while the receiver stalls the next
// command is still taken and worked on, and its result waits until the
// output register is free.
// config writes are only legal while the engine is idle.
`default_nettype none

module cuckoo_filter_engine_core import cfe_pkg::*; #(
  parameter int NUM_BUCKETS      = 1024,
  parameter int SLOTS_PER_BUCKET = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [63:0] key_hash,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [3:0]  match_count,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int RW = SLOTS_PER_BUCKET * 8;
  localparam int SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_B1, S_B2, S_KSWAP, S_KPLACE, S_DONE
  } state_t;

  state_t        state;
  cmd_t          cmd_q;
  logic [7:0]    fp_q;
  logic [BW-1:0] b1;
  logic [BW-1:0] b2;
  logic [BW-1:0] cur;
  logic [BW-1:0] clr_addr;
  logic [RW-1:0] row1;
  logic [RW-1:0] row_cur;
  logic [RW-1:0] fwd_row;
  logic          fwd;
  logic [7:0]    carry;
  logic [9:0]    kicks;
  logic [9:0]    max_kicks;
  logic [15:0]   seed;
  logic [15:0]   lfsr;
  logic          res_ok;
  logic [3:0]    res_cnt;

  logic          mem_we;
  logic [BW-1:0] mem_waddr;
  logic [RW-1:0] mem_wdata;
  logic [BW-1:0] mem_raddr;
  logic [RW-1:0] mem_rdata;

  logic [7:0]    fp_in;
  logic [RW-1:0] row_now;
  logic [7:0]    scan_fp;
  scan_t         s1;
  scan_t         s2;
  logic [15:0]   lfsr_n;
  logic [SW-1:0] kick_idx;
  logic [7:0]    old_fp;
  logic [BW-1:0] alt_next;
  logic [RW-1:0] swap_row;

  function automatic logic [BW-1:0] alt_of(input logic [BW-1:0] b, input logic [7:0] f);
    hash_lo_t hv;
    hv = HASH_TBL[f];
    return b ^ hv[BW-1:0];
  endfunction

  function automatic logic [SW-1:0] pick(input logic [15:0] l);
    logic [4:0] s;
    s = '0;
    if (SLOTS_PER_BUCKET == 3) begin
      // 4 is 1 mod 3, so the base-4 digit sum keeps the residue
      for (int d = 0; d < 8; d++) begin
        s = s + 5'(l[2*d +: 2]);
      end
      for (int k = 0; k < 8; k++) begin
        if (s >= 5'd3) begin
          s = s - 5'd3;
        end
      end
      return SW'(s);
    end
    return l[SW-1:0] & SW'(SLOTS_PER_BUCKET - 1);
  endfunction

  function automatic logic [SW-1:0] first_idx(input logic [MAX_SLOTS-1:0] m);
    logic [SW-1:0] idx;
    idx = '0;
    for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
      if (m[s]) begin
        idx = SW'(s);
      end
    end
    return idx;
  endfunction

  function automatic logic [RW-1:0] set_slot(input logic [RW-1:0] r, input logic [SW-1:0] idx,
                                             input logic [7:0] v);
    logic [RW-1:0] o;
    o = r;
    o[idx*8 +: 8] = v;
    return o;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign fp_in    = (key_hash[7:0] == 8'd0) ? 8'd1 : key_hash[7:0];
  assign row_now  = (state == S_KPLACE && fwd) ? fwd_row : mem_rdata;
  assign scan_fp  = (state == S_KPLACE) ? carry : fp_q;
  assign lfsr_n   = (lfsr >> 1) ^ (lfsr[0] ? LFSR_MASK : 16'd0);
  assign kick_idx = pick(lfsr_n);
  assign old_fp   = row_cur[kick_idx*8 +: 8];
  assign alt_next = alt_of(cur, old_fp);
  assign swap_row = set_slot(row_cur, kick_idx, carry);

  cfe_bucket_ram #(
    .DEPTH (NUM_BUCKETS),
    .WIDTH (RW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cfe_bucket_scan #(.SLOTS(SLOTS_PER_BUCKET)) u_scan1 (
    .row (row1),
    .fp  (fp_q),
    .res (s1)
  );

  cfe_bucket_scan #(.SLOTS(SLOTS_PER_BUCKET)) u_scan2 (
    .row (row_now),
    .fp  (scan_fp),
    .res (s2)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = '0;
    mem_raddr = cur;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      S_IDLE: begin
        mem_raddr = key_hash[BW-1:0];
      end
      S_B1: begin
        mem_raddr = b2;
      end
      S_B2: begin
        if (cmd_q == CMD_ADD) begin
          if (|s1.empty) begin
            mem_we    = 1'b1;
            mem_waddr = b1;
            mem_wdata = set_slot(row1, first_idx(s1.empty), fp_q);
          end else if (|s2.empty) begin
            mem_we    = 1'b1;
            mem_waddr = b2;
            mem_wdata = set_slot(row_now, first_idx(s2.empty), fp_q);
          end
        end else if (cmd_q == CMD_DELETE) begin
          if (|s1.match) begin
            mem_we    = 1'b1;
            mem_waddr = b1;
            mem_wdata = set_slot(row1, first_idx(s1.match), 8'd0);
          end else if (|s2.match) begin
            mem_we    = 1'b1;
            mem_waddr = b2;
            mem_wdata = set_slot(row_now, first_idx(s2.match), 8'd0);
          end
        end
      end
      S_KSWAP: begin
        mem_we    = 1'b1;
        mem_waddr = cur;
        mem_wdata = swap_row;
        mem_raddr = alt_next;
      end
      S_KPLACE: begin
        if (|s2.empty) begin
          mem_we    = 1'b1;
          mem_waddr = cur;
          mem_wdata = set_slot(row_now, first_idx(s2.empty), carry);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      max_kicks <= MAX_KICKS_RESET;
      seed      <= SEED_RESET;
      lfsr      <= SEED_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_KICKS: max_kicks <= cfg_data[9:0];
          CFG_SEED:      seed      <= cfg_data;
          default:       seed      <= seed;
        endcase
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BW'(NUM_BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_q <= cmd_t'(cmd);
            fp_q  <= fp_in;
            b1    <= key_hash[BW-1:0];
            b2    <= alt_of(key_hash[BW-1:0], fp_in);
            state <= S_B1;
          end
        end
        S_B1: begin
          row1  <= mem_rdata;
          state <= S_B2;
        end
        S_B2: begin
          res_ok  <= 1'b0;
          res_cnt <= 4'd0;
          state   <= S_DONE;
          case (cmd_q)
            CMD_ADD: begin
              if ((|s1.empty) || (|s2.empty)) begin
                res_ok <= 1'b1;
              end else if (max_kicks != 10'd0) begin
                lfsr    <= (seed == 16'd0) ? 16'd1 : seed;
                cur     <= b1;
                carry   <= fp_q;
                row_cur <= row1;
                kicks   <= 10'd0;
                state   <= S_KSWAP;
              end
            end
            CMD_CONTAINS, CMD_DELETE: begin
              res_ok <= (|s1.match) || (|s2.match);
            end
            default: begin
              res_cnt <= {1'b0, s1.count} + {1'b0, s2.count};
            end
          endcase
        end
        S_KSWAP: begin
          lfsr    <= lfsr_n;
          carry   <= old_fp;
          cur     <= alt_next;
          fwd     <= (alt_next == cur);
          fwd_row <= swap_row;
          state   <= S_KPLACE;
        end
        S_KPLACE: begin
          if (|s2.empty) begin
            res_ok <= 1'b1;
            state  <= S_DONE;
          end else if (kicks + 10'd1 == max_kicks) begin
            res_ok <= 1'b0;
            state  <= S_DONE;
          end else begin
            kicks   <= kicks + 10'd1;
            row_cur <= row_now;
            state   <= S_KSWAP;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            ok          <= res_ok;
            match_count <= res_cnt;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/cfe_checker.sv */
// port-level checker for the cuckoo filter engine, bound to the top level
`default_nettype none
`include "cuckoo_filter_engine_core_macros.svh"

module cfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       ok,
  input logic [3:0] match_count
);

  `CFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(ok) && $stable(match_count))
  `CFE_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `CFE_ASSERT_IMPL(a_count_not_ok, out_valid && (match_count != 4'd0), !ok)
  `CFE_ASSERT_IMPL(a_count_range, out_valid, match_count <= 4'd8)

endmodule

bind cuckoo_filter_engine_core cfe_checker u_cfe_checker (.*);

`default_nettype wire
